// File: rtl/vvcd_pkg.sv
package vvcd_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_H_LEAD          = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_V_LEAD          = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINES_PER_FRAME = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLOUR_DEPTH    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC_POLARITY   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAIT_FOR_VSYNC  = 3'd7;

  localparam logic [11:0] RST_ACTIVE_WIDTH    = 12'd640;
  localparam logic [11:0] RST_ACTIVE_HEIGHT   = 12'd480;
  localparam logic [11:0] RST_H_LEAD          = 12'd144;
  localparam logic [11:0] RST_V_LEAD          = 12'd35;
  localparam logic [11:0] RST_LINES_PER_FRAME = 12'd525;
  localparam logic [2:0]  RST_COLOUR_DEPTH    = 3'd4;
  localparam logic [1:0]  RST_SYNC_POLARITY   = 2'd3;
  localparam logic        RST_WAIT_FOR_VSYNC  = 1'b1;

  localparam logic [2:0] DEPTH_TWO  = 3'd2;
  localparam logic [2:0] DEPTH_FOUR = 3'd4;

  typedef logic [7:0] comp8_t;

  // expand one colour level to 8 bits
  function automatic comp8_t widen(input logic [3:0] c, input logic [2:0] depth);
    comp8_t res;
    case (depth)
      DEPTH_TWO:  res = {4{c[1:0]}};
      DEPTH_FOUR: res = {2{c}};
      default:    res = (c != 4'd0) ? 8'hFF : 8'h00;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/vga_video_capture_decoder.sv
// VGA capture decoder: takes one sync/colour sample per transfer and returns one result per
// sample. A sample is taken every cycle when the result side keeps up; each result sits in an
// output register in the cycle after its sample, set by the single compute stage between the input
// port and that register. Sync edges, position counters, the registered data-enable and
// coordinates, colour expansion and the line/frame measurements all update together per sample.
// Configuration is written through cfg_we/cfg_index/cfg_data while no sample is in flight.
module vga_video_capture_decoder #(
  parameter int COUNTER_BITS     = 16,
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vvcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [vvcd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_hsync_level,
  input  logic                                in_vsync_level,
  input  logic [3:0]                          in_red_level,
  input  logic [3:0]                          in_green_level,
  input  logic [3:0]                          in_blue_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_pixel_live,
  output logic [15:0]                         out_pixel_x,
  output logic [15:0]                         out_pixel_y,
  output logic [23:0]                         out_pixel_rgb,
  output logic                                out_frame_done,
  output logic                                out_data_enable,
  output logic                                out_is_synced,
  output logic [15:0]                         out_h_position,
  output logic [15:0]                         out_v_position,
  output logic [15:0]                         out_measured_line_length,
  output logic [15:0]                         out_measured_frame_lines,
  output logic [23:0]                         out_frame_pixel_count
);

  localparam int CB = COUNTER_BITS;
  localparam int PB = PIXEL_COUNT_BITS;
  localparam int W  = (CB > 12) ? CB : 12;

  // configuration
  logic [11:0] active_width_r, active_height_r, h_lead_r, v_lead_r, lines_per_frame_r;
  logic [2:0]  colour_depth_r;
  logic [1:0]  sync_polarity_r;
  logic        wait_for_vsync_r;

  // decoder state
  logic [CB-1:0] h_cnt_r, v_cnt_r, col_r, row_r, line_len_r, frame_lines_r;
  logic [CB-1:0] clk_since_h_r, lines_since_v_r;
  logic [PB-1:0] pix_cnt_r;
  logic          hs_last_r, vs_last_r, en_r, synced_r;

  logic [CB-1:0] h_cnt_nxt, v_cnt_nxt, col_nxt, row_nxt, line_len_nxt, frame_lines_nxt;
  logic [CB-1:0] clk_since_h_nxt, lines_since_v_nxt;
  logic [PB-1:0] pix_cnt_nxt;
  logic          en_nxt, synced_nxt;

  logic          allow, pix_hit, h_edge, v_edge, done;
  logic [CB-1:0] h_end, v_end;
  logic [11:0]   v_top;
  logic [23:0]   rgb;

  // result register
  logic          out_valid_r, pix_valid_r, done_r, en_out_r, synced_out_r;
  logic [15:0]   px_r, py_r, hpos_r, vpos_r, llen_r, flines_r;
  logic [23:0]   rgb_r, fpix_r;

  logic in_xfer;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_xfer  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r    <= vvcd_pkg::RST_ACTIVE_WIDTH;
      active_height_r   <= vvcd_pkg::RST_ACTIVE_HEIGHT;
      h_lead_r          <= vvcd_pkg::RST_H_LEAD;
      v_lead_r          <= vvcd_pkg::RST_V_LEAD;
      lines_per_frame_r <= vvcd_pkg::RST_LINES_PER_FRAME;
      colour_depth_r    <= vvcd_pkg::RST_COLOUR_DEPTH;
      sync_polarity_r   <= vvcd_pkg::RST_SYNC_POLARITY;
      wait_for_vsync_r  <= vvcd_pkg::RST_WAIT_FOR_VSYNC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vvcd_pkg::REG_ACTIVE_WIDTH:    active_width_r    <= cfg_data;
        vvcd_pkg::REG_ACTIVE_HEIGHT:   active_height_r   <= cfg_data;
        vvcd_pkg::REG_H_LEAD:          h_lead_r          <= cfg_data;
        vvcd_pkg::REG_V_LEAD:          v_lead_r          <= cfg_data;
        vvcd_pkg::REG_LINES_PER_FRAME: lines_per_frame_r <= cfg_data;
        vvcd_pkg::REG_COLOUR_DEPTH:    colour_depth_r    <= cfg_data[2:0];
        vvcd_pkg::REG_SYNC_POLARITY:   sync_polarity_r   <= cfg_data[1:0];
        vvcd_pkg::REG_WAIT_FOR_VSYNC:  wait_for_vsync_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    allow   = synced_r | ~wait_for_vsync_r;
    h_end   = CB'(CB'(h_lead_r) + CB'(active_width_r));
    v_end   = CB'(CB'(v_lead_r) + CB'(active_height_r));
    pix_hit = en_r & allow & (W'(col_r) < W'(active_width_r))
              & (W'(row_r) < W'(active_height_r));
    rgb     = 24'd0;
    if (pix_hit) begin
      rgb = {vvcd_pkg::widen(in_red_level, colour_depth_r),
             vvcd_pkg::widen(in_green_level, colour_depth_r),
             vvcd_pkg::widen(in_blue_level, colour_depth_r)};
    end
    pix_cnt_nxt = pix_hit ? PB'(pix_cnt_r + PB'(1)) : pix_cnt_r;

    v_edge = (in_vsync_level ^ sync_polarity_r[1]) & ~(vs_last_r ^ sync_polarity_r[1]);
    h_edge = (in_hsync_level ^ sync_polarity_r[0]) & ~(hs_last_r ^ sync_polarity_r[0]);

    done              = v_edge & synced_r;
    frame_lines_nxt   = frame_lines_r;
    lines_since_v_nxt = lines_since_v_r;
    if (done) begin
      frame_lines_nxt   = lines_since_v_r;
      lines_since_v_nxt = '0;
      pix_cnt_nxt       = '0;
    end
    synced_nxt = synced_r | v_edge;

    // line length and line count
    clk_since_h_nxt = CB'(clk_since_h_r + CB'(1));
    line_len_nxt    = line_len_r;
    if (h_edge) begin
      line_len_nxt      = clk_since_h_nxt;
      clk_since_h_nxt   = '0;
      lines_since_v_nxt = CB'(lines_since_v_nxt + CB'(1));
    end

    // position counters
    v_top     = (lines_per_frame_r != 12'd0) ? lines_per_frame_r - 12'd1 : 12'd0;
    h_cnt_nxt = CB'(h_cnt_r + CB'(1));
    v_cnt_nxt = v_cnt_r;
    if (h_edge) begin
      h_cnt_nxt = '0;
      v_cnt_nxt = (W'(v_cnt_r) < W'(v_top)) ? CB'(v_cnt_r + CB'(1)) : '0;
    end
    if (v_edge) begin
      v_cnt_nxt = '0;
    end

    // registered active area and coordinates from the old counters
    en_nxt  = (W'(h_cnt_r) >= W'(h_lead_r)) & (h_cnt_r < h_end)
              & (W'(v_cnt_r) >= W'(v_lead_r)) & (v_cnt_r < v_end);
    col_nxt = (W'(h_cnt_r) >= W'(h_lead_r)) ? CB'(W'(h_cnt_r) - W'(h_lead_r)) : '0;
    row_nxt = (W'(v_cnt_r) >= W'(v_lead_r)) ? CB'(W'(v_cnt_r) - W'(v_lead_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_cnt_r         <= '0;
      v_cnt_r         <= '0;
      hs_last_r       <= 1'b1;
      vs_last_r       <= 1'b1;
      en_r            <= 1'b0;
      col_r           <= '0;
      row_r           <= '0;
      synced_r        <= 1'b0;
      line_len_r      <= '0;
      frame_lines_r   <= '0;
      clk_since_h_r   <= '0;
      lines_since_v_r <= '0;
      pix_cnt_r       <= '0;
    end else if (in_xfer) begin
      h_cnt_r         <= h_cnt_nxt;
      v_cnt_r         <= v_cnt_nxt;
      hs_last_r       <= in_hsync_level;
      vs_last_r       <= in_vsync_level;
      en_r            <= en_nxt;
      col_r           <= col_nxt;
      row_r           <= row_nxt;
      synced_r        <= synced_nxt;
      line_len_r      <= line_len_nxt;
      frame_lines_r   <= frame_lines_nxt;
      clk_since_h_r   <= clk_since_h_nxt;
      lines_since_v_r <= lines_since_v_nxt;
      pix_cnt_r       <= pix_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_valid_r  <= pix_hit;
      px_r         <= pix_hit ? 16'(col_r) : 16'd0;
      py_r         <= pix_hit ? 16'(row_r) : 16'd0;
      rgb_r        <= rgb;
      done_r       <= done;
      en_out_r     <= en_nxt;
      synced_out_r <= synced_nxt;
      hpos_r       <= 16'(h_cnt_nxt);
      vpos_r       <= 16'(v_cnt_nxt);
      llen_r       <= 16'(line_len_nxt);
      flines_r     <= 16'(frame_lines_nxt);
      fpix_r       <= 24'(pix_cnt_nxt);
    end
  end

  assign out_valid                = out_valid_r;
  assign out_pixel_live           = pix_valid_r;
  assign out_pixel_x              = px_r;
  assign out_pixel_y              = py_r;
  assign out_pixel_rgb            = rgb_r;
  assign out_frame_done           = done_r;
  assign out_data_enable          = en_out_r;
  assign out_is_synced            = synced_out_r;
  assign out_h_position           = hpos_r;
  assign out_v_position           = vpos_r;
  assign out_measured_line_length = llen_r;
  assign out_measured_frame_lines = flines_r;
  assign out_frame_pixel_count    = fpix_r;

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("transfer did not load a result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled with free result register");

  a_done_needs_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_done) |-> out_is_synced)
    else $error("frame done while not synced");

  a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pixel_live) |->
      (out_pixel_x == 16'd0 && out_pixel_y == 16'd0 && out_pixel_rgb == 24'd0))
    else $error("pixel payload without pixel");

  a_frame_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_done) |-> (out_frame_pixel_count == 24'd0))
    else $error("pixel count not cleared at frame end");

endmodule

// File: test/vga_video_capture_decoder_checker.sv
`timescale 1ns / 1ps

module vga_video_capture_decoder_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vvcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [vvcd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_hsync_level,
  input  logic                                in_vsync_level,
  input  logic [3:0]                          in_red_level,
  input  logic [3:0]                          in_green_level,
  input  logic [3:0]                          in_blue_level,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_pixel_live,
  input  logic [15:0]                         out_pixel_x,
  input  logic [15:0]                         out_pixel_y,
  input  logic [23:0]                         out_pixel_rgb,
  input  logic                                out_frame_done,
  input  logic                                out_data_enable,
  input  logic                                out_is_synced,
  input  logic [15:0]                         out_h_position,
  input  logic [15:0]                         out_v_position,
  input  logic [15:0]                         out_measured_line_length,
  input  logic [15:0]                         out_measured_frame_lines,
  input  logic [23:0]                         out_frame_pixel_count,
  output int                                  mismatch_total,
  output int                                  samples_in_flight,
  output int                                  pixels_seen,
  output int                                  frames_seen
);

  typedef struct packed {
    logic        pixel_live;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [23:0] pixel_rgb;
    logic        frame_done;
    logic        data_enable;
    logic        is_synced;
    logic [15:0] h_position;
    logic [15:0] v_position;
    logic [15:0] line_length;
    logic [15:0] frame_lines;
    logic [23:0] pixel_count;
  } capture_result_t;

  // timing setup
  logic [11:0] active_w, active_h, lead_h, lead_v, total_lines;
  logic [2:0]  depth;
  logic [1:0]  polarity;
  logic        hold_until_vsync;

  // decoder state
  logic [15:0] h_cnt, v_cnt, col_q, row_q;
  logic [15:0] line_len_q, frame_lines_q, clocks_since_hs, lines_since_vs;
  logic        hs_prev, vs_prev, de_q, synced_q;
  logic [23:0] frame_pixels;

  capture_result_t expected_captures[$];
  capture_result_t want, got;
  int errors, pixel_hits, frame_hits;

  function automatic logic [7:0] expand_level(input logic [3:0] lvl);
    logic [7:0] wide;
    if (depth == vvcd_pkg::DEPTH_FOUR)
      wide = {lvl, lvl};
    else if (depth == vvcd_pkg::DEPTH_TWO)
      wide = {lvl[1:0], lvl[1:0], lvl[1:0], lvl[1:0]};
    else
      wide = (lvl == 4'd0) ? 8'h00 : 8'hFF;
    return wide;
  endfunction

  task automatic decode_sample(input logic hs, input logic vs, input logic [3:0] r,
                               input logic [3:0] g, input logic [3:0] b,
                               output capture_result_t res);
    logic        permit, h_edge, v_edge;
    logic [15:0] h_end, v_end, v_top, h_was, v_was;
    res = '0;
    permit = synced_q || !hold_until_vsync;
    h_end = {4'd0, lead_h} + {4'd0, active_w};
    v_end = {4'd0, lead_v} + {4'd0, active_h};

    if (de_q && permit && col_q < {4'd0, active_w} && row_q < {4'd0, active_h}) begin
      res.pixel_live = 1'b1;
      res.pixel_x = col_q;
      res.pixel_y = row_q;
      res.pixel_rgb = {expand_level(r), expand_level(g), expand_level(b)};
      frame_pixels = frame_pixels + 24'd1;
    end

    v_edge = (vs ^ polarity[1]) && !(vs_prev ^ polarity[1]);
    h_edge = (hs ^ polarity[0]) && !(hs_prev ^ polarity[0]);

    if (v_edge && synced_q) begin
      res.frame_done = 1'b1;
      frame_lines_q = lines_since_vs;
      lines_since_vs = '0;
      frame_pixels = '0;
    end
    if (v_edge)
      synced_q = 1'b1;

    clocks_since_hs = clocks_since_hs + 16'd1;
    if (h_edge) begin
      line_len_q = clocks_since_hs;
      clocks_since_hs = '0;
      lines_since_vs = lines_since_vs + 16'd1;
    end

    h_was = h_cnt;
    v_was = v_cnt;
    hs_prev = hs;
    vs_prev = vs;

    if (h_edge) begin
      h_cnt = '0;
      v_top = (total_lines != 12'd0) ? {4'd0, total_lines} - 16'd1 : 16'd0;
      v_cnt = (v_cnt < v_top) ? v_cnt + 16'd1 : 16'd0;
    end else begin
      h_cnt = h_cnt + 16'd1;
    end
    if (v_edge)
      v_cnt = '0;

    de_q = (h_was >= {4'd0, lead_h}) && (h_was < h_end) &&
           (v_was >= {4'd0, lead_v}) && (v_was < v_end);
    col_q = (h_was >= {4'd0, lead_h}) ? h_was - {4'd0, lead_h} : 16'd0;
    row_q = (v_was >= {4'd0, lead_v}) ? v_was - {4'd0, lead_v} : 16'd0;

    res.data_enable = de_q;
    res.is_synced = synced_q;
    res.h_position = h_cnt;
    res.v_position = v_cnt;
    res.line_length = line_len_q;
    res.frame_lines = frame_lines_q;
    res.pixel_count = frame_pixels;
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_val,
                             input logic [23:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      active_w = vvcd_pkg::RST_ACTIVE_WIDTH;
      active_h = vvcd_pkg::RST_ACTIVE_HEIGHT;
      lead_h = vvcd_pkg::RST_H_LEAD;
      lead_v = vvcd_pkg::RST_V_LEAD;
      total_lines = vvcd_pkg::RST_LINES_PER_FRAME;
      depth = vvcd_pkg::RST_COLOUR_DEPTH;
      polarity = vvcd_pkg::RST_SYNC_POLARITY;
      hold_until_vsync = vvcd_pkg::RST_WAIT_FOR_VSYNC;
      h_cnt = '0;
      v_cnt = '0;
      col_q = '0;
      row_q = '0;
      line_len_q = '0;
      frame_lines_q = '0;
      clocks_since_hs = '0;
      lines_since_vs = '0;
      hs_prev = 1'b1;
      vs_prev = 1'b1;
      de_q = 1'b0;
      synced_q = 1'b0;
      frame_pixels = '0;
      expected_captures.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_pixel_live, out_pixel_x, out_pixel_y, out_pixel_rgb, out_frame_done,
                out_data_enable, out_is_synced, out_h_position, out_v_position,
                out_measured_line_length, out_measured_frame_lines, out_frame_pixel_count};
        if (expected_captures.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got %h", $time, got);
          errors++;
        end else begin
          want = expected_captures.pop_front();
          check_field("pixel_live", 24'(want.pixel_live), 24'(got.pixel_live));
          check_field("pixel_x", 24'(want.pixel_x), 24'(got.pixel_x));
          check_field("pixel_y", 24'(want.pixel_y), 24'(got.pixel_y));
          check_field("pixel_rgb", want.pixel_rgb, got.pixel_rgb);
          check_field("frame_done", 24'(want.frame_done), 24'(got.frame_done));
          check_field("data_enable", 24'(want.data_enable), 24'(got.data_enable));
          check_field("is_synced", 24'(want.is_synced), 24'(got.is_synced));
          check_field("h_position", 24'(want.h_position), 24'(got.h_position));
          check_field("v_position", 24'(want.v_position), 24'(got.v_position));
          check_field("measured_line_length", 24'(want.line_length), 24'(got.line_length));
          check_field("measured_frame_lines", 24'(want.frame_lines), 24'(got.frame_lines));
          check_field("frame_pixel_count", want.pixel_count, got.pixel_count);
          if (want.pixel_live)
            pixel_hits++;
          if (want.frame_done)
            frame_hits++;
        end
      end

      if (in_valid && in_ready) begin
        decode_sample(in_hsync_level, in_vsync_level, in_red_level, in_green_level,
                      in_blue_level, want);
        expected_captures.push_back(want);
      end

      if (cfg_we) begin
        case (cfg_index)
          vvcd_pkg::REG_ACTIVE_WIDTH:    active_w = cfg_data;
          vvcd_pkg::REG_ACTIVE_HEIGHT:   active_h = cfg_data;
          vvcd_pkg::REG_H_LEAD:          lead_h = cfg_data;
          vvcd_pkg::REG_V_LEAD:          lead_v = cfg_data;
          vvcd_pkg::REG_LINES_PER_FRAME: total_lines = cfg_data;
          vvcd_pkg::REG_COLOUR_DEPTH:    depth = cfg_data[2:0];
          vvcd_pkg::REG_SYNC_POLARITY:   polarity = cfg_data[1:0];
          vvcd_pkg::REG_WAIT_FOR_VSYNC:  hold_until_vsync = cfg_data[0];
          default: ;
        endcase
      end
    end

    mismatch_total <= errors;
    samples_in_flight <= expected_captures.size();
    pixels_seen <= pixel_hits;
    frames_seen <= frame_hits;
  end

endmodule

// File: test/vga_video_capture_decoder_tb.sv
`timescale 1ns / 1ps

module vga_video_capture_decoder_tb;

  localparam int SAMPLE_TARGET = 1500;
  localparam int CYCLE_LIMIT   = 600000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [vvcd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [vvcd_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_hsync_level = 1'b1;
  logic        in_vsync_level = 1'b1;
  logic [3:0]  in_red_level = '0;
  logic [3:0]  in_green_level = '0;
  logic [3:0]  in_blue_level = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_pixel_live;
  logic [15:0] out_pixel_x, out_pixel_y;
  logic [23:0] out_pixel_rgb;
  logic        out_frame_done, out_data_enable, out_is_synced;
  logic [15:0] out_h_position, out_v_position;
  logic [15:0] out_measured_line_length, out_measured_frame_lines;
  logic [23:0] out_frame_pixel_count;

  int mismatch_total, samples_in_flight, pixels_seen, frames_seen;
  int samples_sent = 0;
  int cycle_count = 0;
  bit steady_source = 1'b0;

  vga_video_capture_decoder dut (.*);

  vga_video_capture_decoder_checker capture_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    else if (roll < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: runs of ready with stalls in between
  initial begin
    int run_len, stall_len;
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic drive_sample(input logic hs, input logic vs, input logic [3:0] r,
                              input logic [3:0] g, input logic [3:0] b);
    int gap;
    gap = steady_source ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hsync_level <= hs;
    in_vsync_level <= vs;
    in_red_level <= r;
    in_green_level <= g;
    in_blue_level <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drive_noise(input int count);
    repeat (count)
      drive_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)));
  endtask

  // one frame of sync timing; stops early after cut samples
  task automatic send_frame(input int hs_w, input int h_total, input int vs_w,
                            input int v_lines, input int vs_offset, input int cut,
                            input logic [1:0] gen_pol);
    int k;
    logic hs_on, vs_on;
    k = 0;
    for (int line = 0; line < v_lines; line++) begin
      for (int col = 0; col < h_total; col++) begin
        if (k >= cut)
          return;
        hs_on = (col < hs_w);
        vs_on = (k >= vs_offset) && (k < vs_offset + vs_w * h_total);
        drive_sample(hs_on ^ gen_pol[0], vs_on ^ gen_pol[1], 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        k++;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_in_flight != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vvcd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [11:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // narrow registers get random upper bits that must be ignored
  task automatic program_timing(input logic [11:0] aw, input logic [11:0] ah,
                                input logic [11:0] hl, input logic [11:0] vl,
                                input logic [11:0] lpf, input logic [2:0] depth,
                                input logic [1:0] pol, input logic wv);
    logic [11:0] junk;
    junk = 12'($urandom_range(0, 4095));
    write_reg(vvcd_pkg::REG_ACTIVE_WIDTH, aw);
    write_reg(vvcd_pkg::REG_ACTIVE_HEIGHT, ah);
    write_reg(vvcd_pkg::REG_H_LEAD, hl);
    write_reg(vvcd_pkg::REG_V_LEAD, vl);
    write_reg(vvcd_pkg::REG_LINES_PER_FRAME, lpf);
    write_reg(vvcd_pkg::REG_COLOUR_DEPTH, {junk[11:3], depth});
    write_reg(vvcd_pkg::REG_SYNC_POLARITY, {junk[9:0], pol});
    write_reg(vvcd_pkg::REG_WAIT_FOR_VSYNC, {junk[10:0], wv});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    int aw, ah, hl, vl, lpf, fp, hs_w, h_total, vs_w, v_lines, frames, cut, vs_offset;
    logic [2:0] depth;
    logic [1:0] pol, gen_pol;
    logic wv;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup, vsync held inactive so the decoder stays unsynced
    drive_sample(1'b1, 1'b1, 4'd0, 4'd0, 4'd0);
    drive_sample(1'b0, 1'b1, 4'd15, 4'd15, 4'd15);
    drive_sample(1'b0, 1'b1, 4'd15, 4'd0, 4'd15);
    drive_sample(1'b1, 1'b1, 4'd0, 4'd15, 4'd0);
    drive_sample(1'b0, 1'b1, 4'd1, 4'd2, 4'd4);
    drive_sample(1'b1, 1'b1, 4'd8, 4'd8, 4'd8);
    drive_sample(1'b1, 1'b1, 4'd3, 4'd12, 4'd5);
    drive_sample(1'b0, 1'b1, 4'd10, 4'd6, 4'd9);

    // pixels allowed before any vsync edge
    wait_idle();
    program_timing(12'd3, 12'd2, 12'd1, 12'd0, 12'd3, vvcd_pkg::DEPTH_FOUR, 2'd3, 1'b0);
    for (int k = 0; k < 18; k++)
      drive_sample((k % 6) != 0, 1'b1, k[3:0], ~k[3:0], k[3:0] ^ 4'hA);

    phase = 0;
    while (samples_sent < SAMPLE_TARGET || phase < 10) begin
      aw = $urandom_range(1, 6);
      hl = $urandom_range(1, 4);
      fp = $urandom_range(0, 2);
      hs_w = $urandom_range(1, hl);
      h_total = hl + aw + fp;
      ah = $urandom_range(1, 3);
      vl = $urandom_range(0, 2);
      vs_w = $urandom_range(1, (vl > 0) ? vl : 1);
      v_lines = vl + ah + $urandom_range(0, 1);
      if (v_lines < vs_w + 1)
        v_lines = vs_w + 1;
      lpf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : v_lines;
      depth = 3'(phase % 8);
      pol = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
      wv = (phase < 2) ? 1'(phase) : 1'($urandom_range(0, 1));

      case (phase)
        0: begin
          aw = 4095; ah = 4095; hl = 0; vl = 0; lpf = 4095;
        end
        1: begin
          aw = 1; ah = 1; hl = 4095; vl = 4095; lpf = 0;
        end
        2: lpf = 1;
        default: ;
      endcase

      wait_idle();
      program_timing(12'(aw), 12'(ah), 12'(hl), 12'(vl), 12'(lpf), depth, pol, wv);
      steady_source = ($urandom_range(0, 3) == 0);
      gen_pol = ($urandom_range(0, 7) == 0) ? ~pol : pol;

      if ($urandom_range(0, 3) == 0)
        drive_noise($urandom_range(5, 20));
      frames = $urandom_range(2, 4);
      repeat (frames) begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, h_total * v_lines - 1)
                                          : h_total * v_lines;
        vs_offset = ($urandom_range(0, 3) == 0) ? $urandom_range(1, h_total - 1) : 0;
        send_frame(hs_w, h_total, vs_w, v_lines, vs_offset, cut, gen_pol);
      end
      if ($urandom_range(0, 5) == 0)
        drive_noise($urandom_range(2, 8));
      phase++;
    end

    wait_idle();
    repeat (5) @(posedge clk);
    $display("sent %0d samples across %0d timing setups", samples_sent, phase + 2);
    $display("checked %0d delivered pixels and %0d completed frames", pixels_seen, frames_seen);
    if (mismatch_total == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
